>>> rtl/sle_pkg.sv
// Shared types, codes and default sizes for the sequential list engine.
package sle_pkg;

	localparam int CAPACITY_DEF   = 16;
	localparam int ELEM_WIDTH_DEF = 32;

	// Match bits examined by the locate scanner in each cycle.
	localparam int SCAN_GROUP = 8;

	localparam logic [1:0] ACT_INSERT = 2'd0;
	localparam logic [1:0] ACT_DELETE = 2'd1;
	localparam logic [1:0] ACT_LOCATE = 2'd2;
	localparam logic [1:0] ACT_GET    = 2'd3;

	localparam logic [1:0] STS_OK        = 2'd0;
	localparam logic [1:0] STS_BAD_POS   = 2'd1;
	localparam logic [1:0] STS_FULL      = 2'd2;
	localparam logic [1:0] STS_NOT_FOUND = 2'd3;

	typedef struct packed {
		logic [1:0]         action;
		logic [4:0]         position;
		logic signed [31:0] item_value;
	} req_beat_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] out_value;
		logic [3:0]         found_index;
		logic [4:0]         count_now;
	} rsp_beat_t;

	typedef struct packed {
		logic ins;
		logic del;
	} sle_cell_ctl_t;

	typedef struct packed {
		logic done;
		logic found;
	} sle_scan_res_t;

endpackage

>>> rtl/sequential_list_engine_core.sv
// Top level of the sequential list engine: request decode, cell chain, scanner and result register.
//
// The list lives in a chain of CAPACITY cells, one entry each, with a length
// count beside it. Insert, delete and get finish in the cycle their request
// beat is taken: every cell shifts or loads at once and the entry at the
// position is read straight out of the chain. Locate compares all cells in
// parallel in that same cycle, then a scanner walks the match bits eight
// cells per cycle, stopping at the first group that holds a match or at
// the last group; how long a locate takes depends on where the first match lies.
// Results sit in an output register; a new request beat is taken whenever
// no locate is in progress and that register is empty or being emptied in
// the same cycle. Entries above the length are never read, so the cells
// need no clearing after reset.
module sequential_list_engine_core import sle_pkg::*; #(
	parameter int CAPACITY   = CAPACITY_DEF,
	parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_beat_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_beat_t rsp
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > 5) ? CW : 5;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_SCAN = 1'b1;

	localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

	logic            state_q;
	logic [CW-1:0]   count_q;
	logic            rsp_valid_q;
	rsp_beat_t       rsp_q;

	logic            take;
	logic            out_free;
	logic [CMPW-1:0] pos_c;
	logic [CMPW-1:0] cnt_c;
	logic            pos_le_cnt;
	logic            pos_lt_cnt;
	logic            is_full;
	logic            ins_ok;
	logic            del_ok;
	logic [IW-1:0]   pos_idx;
	logic [63:0]     in_wide;
	logic [ELEM_WIDTH-1:0] elem_val;
	logic signed [ELEM_WIDTH-1:0] rd_data;
	logic [63:0]     rd_wide;
	logic signed [31:0] rd_out;
	logic [63:0]     cnt_wide;
	logic [CW-1:0]   count_next;
	logic [63:0]     cnt_next_wide;

	sle_cell_ctl_t   cell_ctl;
	logic [ELEM_WIDTH-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0]   cell_hit;

	sle_scan_res_t   scan_res;
	logic [IW-1:0]   scan_idx;
	logic [63:0]     scan_idx_wide;
	logic            scan_start;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && out_free;
	assign take      = req_valid && req_ready;

	assign pos_c      = CMPW'(req.position);
	assign cnt_c      = CMPW'(count_q);
	assign pos_le_cnt = pos_c <= cnt_c;
	assign pos_lt_cnt = pos_c < cnt_c;
	assign is_full    = count_q >= CAP_CNT;
	assign pos_idx    = IW'(req.position);

	assign ins_ok     = take && (req.action == ACT_INSERT) && pos_le_cnt && !is_full;
	assign del_ok     = take && (req.action == ACT_DELETE) && pos_lt_cnt;
	assign scan_start = take && (req.action == ACT_LOCATE);

	assign cell_ctl.ins = ins_ok;
	assign cell_ctl.del = del_ok;

	// Input values are sign-extended, then cut to the element width.
	assign in_wide  = 64'(req.item_value);
	assign elem_val = in_wide[ELEM_WIDTH-1:0];

	assign rd_data  = cell_data[pos_idx];
	assign rd_wide  = 64'(rd_data);
	assign rd_out   = rd_wide[31:0];
	assign cnt_wide = 64'(count_q);
	assign cnt_next_wide = 64'(count_next);
	assign scan_idx_wide = 64'(scan_idx);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [ELEM_WIDTH-1:0] left_d;
		logic [ELEM_WIDTH-1:0] right_d;

		if (i == 0) begin : g_first
			assign left_d = cell_data[i];
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end

		sle_cell #(
			.IDX (i),
			.IW  (IW),
			.CW  (CW),
			.EW  (ELEM_WIDTH)
		) u_cell (
			.clk        (clk),
			.ctl        (cell_ctl),
			.pos        (pos_idx),
			.count      (count_q),
			.new_val    (elem_val),
			.cmp_val    (elem_val),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[i]),
			.hit        (cell_hit[i])
		);
	end

	sle_scan #(
		.CAPACITY (CAPACITY),
		.IW       (IW)
	) u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (scan_start),
		.hits   (cell_hit),
		.res    (scan_res),
		.index  (scan_idx)
	);

	always_comb begin
		count_next = count_q;
		if (ins_ok) begin
			count_next = count_q + 1'b1;
		end else if (del_ok) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			count_q <= count_next;
			unique case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						state_q     <= ST_SCAN;
						rsp_valid_q <= 1'b0;
					end else if (take) begin
						rsp_valid_q <= 1'b1;
					end else if (rsp_ready) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					if (scan_res.done) begin
						state_q     <= ST_IDLE;
						rsp_valid_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result beat payload; a locate result is filled in when the scanner finishes.
	always_ff @(posedge clk) begin
		if (take && !scan_start) begin
			rsp_q.status      <= STS_OK;
			rsp_q.out_value   <= '0;
			rsp_q.found_index <= '0;
			rsp_q.count_now   <= cnt_next_wide[4:0];
			case (req.action)
				ACT_INSERT: begin
					if (!pos_le_cnt) begin
						rsp_q.status <= STS_BAD_POS;
					end else if (is_full) begin
						rsp_q.status <= STS_FULL;
					end
				end
				ACT_DELETE, ACT_GET: begin
					if (!pos_lt_cnt) begin
						rsp_q.status <= STS_BAD_POS;
					end else begin
						rsp_q.out_value <= rd_out;
					end
				end
				default: begin
					rsp_q.status <= STS_OK;
				end
			endcase
		end else if ((state_q == ST_SCAN) && scan_res.done) begin
			rsp_q.status      <= scan_res.found ? STS_OK : STS_NOT_FOUND;
			rsp_q.out_value   <= '0;
			rsp_q.found_index <= scan_res.found ? scan_idx_wide[3:0] : 4'd0;
			rsp_q.count_now   <= cnt_wide[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// The result register must be empty whenever a scan completes.
	a_scan_done_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) && scan_res.done |-> !rsp_valid_q)
		else $error("locate finished while a result was still held");

	// A successful insert grows the list by exactly one.
	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		ins_ok |=> count_q == $past(count_q) + 1'b1)
		else $error("insert did not advance the length by one");

	// The length never passes the capacity.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CAP_CNT)
		else $error("length exceeds capacity");

	// A locate request leaves the block scanning with no result shown.
	a_locate_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_start |=> (state_q == ST_SCAN) && !rsp_valid_q && $stable(count_q))
		else $error("locate did not start a scan cleanly");

endmodule

>>> rtl/sle_cell.sv
// One list cell: holds a single entry, shifts with its neighbours and flags a match.
module sle_cell import sle_pkg::*; #(
	parameter int IDX = 0,
	parameter int IW  = 4,
	parameter int CW  = 5,
	parameter int EW  = ELEM_WIDTH_DEF
) (
	input  logic          clk,
	input  sle_cell_ctl_t ctl,
	input  logic [IW-1:0] pos,
	input  logic [CW-1:0] count,
	input  logic [EW-1:0] new_val,
	input  logic [EW-1:0] cmp_val,
	input  logic [EW-1:0] left_data,
	input  logic [EW-1:0] right_data,
	output logic [EW-1:0] data,
	output logic          hit
);

	localparam logic [IW-1:0] MY_POS = IW'(IDX);
	localparam logic [CW-1:0] MY_CNT = CW'(IDX);

	logic [EW-1:0] data_q;

	// Insert opens a gap at pos by pulling from the left; delete closes it from the right.
	always_ff @(posedge clk) begin
		if (ctl.ins) begin
			if (MY_POS == pos) begin
				data_q <= new_val;
			end else if (MY_POS > pos) begin
				data_q <= left_data;
			end
		end else if (ctl.del) begin
			if (MY_POS >= pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data = data_q;
	assign hit  = (MY_CNT < count) && (data_q == cmp_val);

endmodule

>>> rtl/sle_scan.sv
// Locate scanner: walks the captured match bits a group at a time for the first hit.
module sle_scan import sle_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int IW       = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [CAPACITY-1:0] hits,
	output sle_scan_res_t       res,
	output logic [IW-1:0]       index
);

	localparam int NG   = (CAPACITY + SCAN_GROUP - 1) / SCAN_GROUP;
	localparam int PADW = NG * SCAN_GROUP;
	localparam int GW   = (NG > 1) ? $clog2(NG) : 1;
	localparam int EGW  = $clog2(SCAN_GROUP);
	localparam logic [GW-1:0] LAST_GRP = GW'(NG - 1);

	logic [PADW-1:0]    hits_q;
	logic [GW-1:0]      grp_q;
	logic               busy_q;
	logic               grp_any;
	logic [EGW-1:0]     enc;
	logic [GW+EGW-1:0]  index_wide;

	assign grp_any = |hits_q[SCAN_GROUP-1:0];

	always_comb begin
		enc = '0;
		for (int k = SCAN_GROUP - 1; k >= 0; k--) begin
			if (hits_q[k]) begin
				enc = EGW'(k);
			end
		end
	end

	assign res.done   = busy_q && (grp_any || (grp_q == LAST_GRP));
	assign res.found  = busy_q && grp_any;
	assign index_wide = {grp_q, enc};
	assign index      = index_wide[IW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q) begin
			if (res.done) begin
				busy_q <= 1'b0;
			end else begin
				grp_q <= grp_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			hits_q <= PADW'(hits);
		end else if (busy_q) begin
			hits_q <= hits_q >> SCAN_GROUP;
		end
	end

endmodule
